>>> hdl/lwcs_pkg.sv
// ----------------------------------------------------------------------------
// LCD window sequencer package
// Shared types, command codes, register indexes and panel command bytes.
// ----------------------------------------------------------------------------
package lwcs_pkg;

  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 11;
  localparam int DIR_W       = 2;
  localparam int CMD_W       = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int NUM_STEPS   = 13;
  localparam int STEP_W      = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CMD_W-1:0] CMD_SET_WINDOW  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW_POINT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BEGIN_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PIXEL       = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [DIR_W-1:0] DIR_X_NEAR = 2'd0;
  localparam logic [DIR_W-1:0] DIR_X_FAR  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_Y_FAR  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_Y_NEAR = 2'd3;

  localparam logic [7:0] DCS_COLUMN_SET = 8'h2A;
  localparam logic [7:0] DCS_ROW_SET    = 8'h2B;
  localparam logic [7:0] DCS_MEM_WRITE  = 8'h2C;

  localparam logic [COORD_W-1:0] OFFSET_NEAR = 16'd12;
  localparam logic [COORD_W-1:0] OFFSET_FAR  = 16'd14;
  localparam logic [COORD_W-1:0] CACHE_RESET = 16'hFFFF;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 11'd240;

  // Byte slots of one job, in transfer order.
  localparam logic [STEP_W-1:0] STEP_COL_CMD   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_COL_S_HI  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_COL_S_LO  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_COL_E_HI  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_COL_E_LO  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ROW_CMD   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ROW_S_HI  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ROW_S_LO  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ROW_E_HI  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ROW_E_LO  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MEM_CMD   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_COLOR_HI  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_COLOR_LO  = 4'd12;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] coord_x0;
    logic [COORD_W-1:0] coord_y0;
    logic [COORD_W-1:0] coord_x1;
    logic [COORD_W-1:0] coord_y1;
    logic [COORD_W-1:0] pixel_color;
  } request_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic               col_en;
    logic               row_en;
    logic               mem_en;
    logic               color_en;
    logic [COORD_W-1:0] col_start;
    logic [COORD_W-1:0] col_end;
    logic [COORD_W-1:0] row_start;
    logic [COORD_W-1:0] row_end;
    logic [COORD_W-1:0] color;
  } job_t;

  function automatic logic [NUM_STEPS-1:0] job_mask(input job_t j);
    logic [NUM_STEPS-1:0] m;
    m = '0;
    m[4:0]   = {5{j.col_en}};
    m[9:5]   = {5{j.row_en}};
    m[10]    = j.mem_en;
    m[12:11] = {2{j.color_en}};
    return m;
  endfunction

endpackage

>>> hdl/lwcs_front.sv
// ----------------------------------------------------------------------------
// LCD window sequencer front end
// Holds the panel registers and the address cache, clamps and offsets the
// window of each request and writes a job record for the back end.
// ----------------------------------------------------------------------------
module lwcs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [lwcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lwcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  lwcs_pkg::request_t             request,
  input  logic                           push,
  output logic                           full,
  input  logic                           q_full,
  output logic                           q_write,
  output lwcs_pkg::job_t                 q_job
);
  import lwcs_pkg::*;

  logic [DIR_W-1:0]   direction;
  logic [SIZE_W-1:0]  panel_width;
  logic [SIZE_W-1:0]  panel_height;
  logic [COORD_W-1:0] cached_col_start;
  logic [COORD_W-1:0] cached_col_end;
  logic [COORD_W-1:0] cached_row_start;
  logic [COORD_W-1:0] cached_row_end;

  logic [COORD_W-1:0] width_ext;
  logic [COORD_W-1:0] height_ext;
  logic [COORD_W-1:0] xmax;
  logic [COORD_W-1:0] ymax;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [COORD_W-1:0] src_x1;
  logic [COORD_W-1:0] src_y1;
  logic [COORD_W-1:0] clamp_x1;
  logic [COORD_W-1:0] clamp_y1;
  logic               is_window;
  logic               is_point;
  logic               in_range;
  logic               accept;
  job_t               job;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= DIR_X_NEAR;
      panel_width  <= SIZE_RESET;
      panel_height <= SIZE_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_DIRECTION: direction    <= cfg_data[DIR_W-1:0];
        REG_WIDTH:     panel_width  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:    panel_height <= cfg_data[SIZE_W-1:0];
        default:       ;
      endcase
    end
  end

  assign width_ext  = {{(COORD_W-SIZE_W){1'b0}}, panel_width};
  assign height_ext = {{(COORD_W-SIZE_W){1'b0}}, panel_height};
  assign xmax       = width_ext - 16'd1;
  assign ymax       = height_ext - 16'd1;

  always_comb begin
    dx = '0;
    dy = '0;
    case (direction)
      DIR_X_NEAR: dx = OFFSET_NEAR;
      DIR_X_FAR:  dx = OFFSET_FAR;
      DIR_Y_FAR:  dy = OFFSET_FAR;
      default:    dy = OFFSET_NEAR;
    endcase
  end

  assign is_window = (request.command == CMD_SET_WINDOW);
  assign is_point  = (request.command == CMD_DRAW_POINT);
  assign in_range  = (request.coord_x0 < width_ext) && (request.coord_y0 < height_ext);
  assign src_x1    = is_point ? request.coord_x0 : request.coord_x1;
  assign src_y1    = is_point ? request.coord_y0 : request.coord_y1;
  assign clamp_x1  = (src_x1 >= width_ext) ? xmax : src_x1;
  assign clamp_y1  = (src_y1 >= height_ext) ? ymax : src_y1;

  always_comb begin
    job           = '0;
    job.col_start = request.coord_x0 + dx;
    job.col_end   = clamp_x1 + dx;
    job.row_start = request.coord_y0 + dy;
    job.row_end   = clamp_y1 + dy;
    job.color     = request.pixel_color;
    case (request.command)
      CMD_SET_WINDOW, CMD_DRAW_POINT: begin
        job.col_en = (job.col_start != cached_col_start) || (job.col_end != cached_col_end);
        job.row_en = (job.row_start != cached_row_start) || (job.row_end != cached_row_end);
        job.mem_en   = is_point;
        job.color_en = is_point;
      end
      CMD_BEGIN_WRITE: job.mem_en = 1'b1;
      default:         job.color_en = 1'b1;
    endcase
  end

  assign full    = q_full;
  assign accept  = push && !q_full && (is_window || !is_point || in_range);
  assign q_write = accept && (job.col_en || job.row_en || job.mem_en || job.color_en);
  assign q_job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cached_col_start <= CACHE_RESET;
      cached_col_end   <= CACHE_RESET;
      cached_row_start <= CACHE_RESET;
      cached_row_end   <= CACHE_RESET;
    end else if (accept) begin
      if (job.col_en) begin
        cached_col_start <= job.col_start;
        cached_col_end   <= job.col_end;
      end
      if (job.row_en) begin
        cached_row_start <= job.row_start;
        cached_row_end   <= job.row_end;
      end
    end
  end

endmodule

>>> hdl/lwcs_queue.sv
// ----------------------------------------------------------------------------
// LCD window sequencer job queue
// Short first-in first-out buffer of job records between front and back end.
// ----------------------------------------------------------------------------
module lwcs_queue #(
  parameter int DEPTH = lwcs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  lwcs_pkg::job_t wr_job,
  output logic           q_full,
  input  logic           rd,
  output logic           q_valid,
  output lwcs_pkg::job_t rd_job
);
  import lwcs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/lwcs_back.sv
// ----------------------------------------------------------------------------
// LCD window sequencer back end
// Walks the byte slots of one job at a time and fills the result register.
// ----------------------------------------------------------------------------
module lwcs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  lwcs_pkg::job_t      q_job,
  output logic                q_read,
  output lwcs_pkg::result_t   result,
  output logic                empty,
  input  logic                pop
);
  import lwcs_pkg::*;

  job_t                 job;
  logic                 job_valid;
  logic [NUM_STEPS-1:0] rem;
  logic [NUM_STEPS-1:0] low_bit;
  logic [STEP_W-1:0]    step;
  logic                 final_byte;
  logic                 emit;
  logic                 load_job;
  logic                 out_valid;
  result_t              out_reg;
  result_t              out_next;

  assign low_bit    = rem & (~rem + 1'b1);
  assign final_byte = (rem == low_bit);
  assign emit       = job_valid && (!out_valid || pop);
  assign load_job   = !job_valid || (emit && final_byte);
  assign q_read     = load_job && q_valid;

  always_comb begin
    step = '0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      if (low_bit[i]) begin
        step = STEP_W'(i);
      end
    end
  end

  always_comb begin
    out_next.is_data = 1'b1;
    out_next.last    = final_byte;
    case (step)
      STEP_COL_CMD: begin
        out_next.out_byte = DCS_COLUMN_SET;
        out_next.is_data  = 1'b0;
      end
      STEP_COL_S_HI: out_next.out_byte = job.col_start[15:8];
      STEP_COL_S_LO: out_next.out_byte = job.col_start[7:0];
      STEP_COL_E_HI: out_next.out_byte = job.col_end[15:8];
      STEP_COL_E_LO: out_next.out_byte = job.col_end[7:0];
      STEP_ROW_CMD: begin
        out_next.out_byte = DCS_ROW_SET;
        out_next.is_data  = 1'b0;
      end
      STEP_ROW_S_HI: out_next.out_byte = job.row_start[15:8];
      STEP_ROW_S_LO: out_next.out_byte = job.row_start[7:0];
      STEP_ROW_E_HI: out_next.out_byte = job.row_end[15:8];
      STEP_ROW_E_LO: out_next.out_byte = job.row_end[7:0];
      STEP_MEM_CMD: begin
        out_next.out_byte = DCS_MEM_WRITE;
        out_next.is_data  = 1'b0;
      end
      STEP_COLOR_HI: out_next.out_byte = job.color[15:8];
      default:       out_next.out_byte = job.color[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      rem       <= '0;
    end else if (load_job) begin
      job_valid <= q_valid;
      rem       <= q_valid ? job_mask(q_job) : '0;
    end else if (emit) begin
      rem <= rem & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (load_job && q_valid) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg <= out_next;
    end
  end

  assign result = out_reg;
  assign empty  = !out_valid;

`ifndef ASSERT_OFF
  a_job_has_bytes: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (rem != '0))
    else $error("active job has no bytes left");

  a_job_loads: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !job_valid) |=> job_valid)
    else $error("waiting job was not taken by the idle back end");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.last) |-> job_valid)
    else $error("non-final byte shown without a job in progress");
`endif

endmodule

>>> hdl/lcd_window_command_sequencer.sv
// ----------------------------------------------------------------------------
// LCD window command sequencer
// Path: the first byte of a request goes through the queue, the job register
// of the back end and the result register to the result ports. Throughput:
// one byte per cycle while bytes are waiting and pop is held; 0 to 13 per request.
// Reset: synchronous; clears the queue, the result valid flag, the panel
// registers (direction 0, 240 by 240) and the address cache (all ones).
// ----------------------------------------------------------------------------
module lcd_window_command_sequencer #(
  parameter int QUEUE_DEPTH = lwcs_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [lwcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lwcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  lwcs_pkg::request_t               request,
  input  logic                             push,
  output logic                             full,
  output lwcs_pkg::result_t                result,
  output logic                             empty,
  input  logic                             pop
);
  import lwcs_pkg::*;

  logic q_full;
  logic q_write;
  logic q_read;
  logic q_valid;
  job_t wr_job;
  job_t rd_job;

  lwcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .push      (push),
    .full      (full),
    .q_full    (q_full),
    .q_write   (q_write),
    .q_job     (wr_job)
  );

  lwcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_write),
    .wr_job  (wr_job),
    .q_full  (q_full),
    .rd      (q_read),
    .q_valid (q_valid),
    .rd_job  (rd_job)
  );

  lwcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (rd_job),
    .q_read  (q_read),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

>>> bench/lcd_window_command_sequencer_tb.sv
// ----------------------------------------------------------------------------
// LCD window command sequencer testbench
// Drives window, point, begin-write and pixel requests through the request
// queue under several panel settings. A scoreboard predicts the panel byte
// stream from its own copy of the address cache and checks every byte
// transfer in order. Both sides idle in random bursts except in the last
// phase.
// ----------------------------------------------------------------------------
module lcd_window_command_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lwcs_pkg::*;

  localparam int RANDOM_PER_PHASE = 40;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int SETTLE_CYCLES    = 20;

  class dcs_stream_scoreboard;
    logic [DIR_W-1:0]   direction;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [COORD_W-1:0] col_start;
    logic [COORD_W-1:0] col_end;
    logic [COORD_W-1:0] row_start;
    logic [COORD_W-1:0] row_end;
    result_t            expected_bytes[$];
    int                 mismatches;

    function new();
      direction  = DIR_X_NEAR;
      width      = SIZE_RESET;
      height     = SIZE_RESET;
      col_start  = CACHE_RESET;
      col_end    = CACHE_RESET;
      row_start  = CACHE_RESET;
      row_end    = CACHE_RESET;
      mismatches = 0;
    endfunction

    function void add_byte(logic [7:0] value, logic data);
      result_t b;
      b.out_byte = value;
      b.is_data  = data;
      b.last     = 1'b0;
      expected_bytes.push_back(b);
    endfunction

    function void add_address(logic [7:0] opcode, logic [15:0] a, logic [15:0] b);
      add_byte(opcode, 1'b0);
      add_byte(a[15:8], 1'b1);
      add_byte(a[7:0], 1'b1);
      add_byte(b[15:8], 1'b1);
      add_byte(b[7:0], 1'b1);
    endfunction

    function void add_window(logic [15:0] x0, logic [15:0] y0,
                             logic [15:0] x1, logic [15:0] y1);
      logic [15:0] xmax;
      logic [15:0] ymax;
      logic [15:0] dx;
      logic [15:0] dy;
      xmax = {5'd0, width} - 16'd1;
      ymax = {5'd0, height} - 16'd1;
      dx   = '0;
      dy   = '0;
      if ({5'd0, width} <= x1) x1 = xmax;
      if ({5'd0, height} <= y1) y1 = ymax;
      case (direction)
        DIR_X_NEAR: dx = OFFSET_NEAR;
        DIR_X_FAR:  dx = OFFSET_FAR;
        DIR_Y_FAR:  dy = OFFSET_FAR;
        default:    dy = OFFSET_NEAR;
      endcase
      x0 = x0 + dx;
      x1 = x1 + dx;
      y0 = y0 + dy;
      y1 = y1 + dy;
      if (x0 != col_start || x1 != col_end) begin
        add_address(DCS_COLUMN_SET, x0, x1);
        col_start = x0;
        col_end   = x1;
      end
      if (y0 != row_start || y1 != row_end) begin
        add_address(DCS_ROW_SET, y0, y1);
        row_start = y0;
        row_end   = y1;
      end
    endfunction

    function void note_request(request_t r);
      int      start_count;
      result_t tail;
      start_count = expected_bytes.size();
      case (r.command)
        CMD_SET_WINDOW: add_window(r.coord_x0, r.coord_y0, r.coord_x1, r.coord_y1);
        CMD_DRAW_POINT: begin
          if ({5'd0, width} > r.coord_x0 && {5'd0, height} > r.coord_y0) begin
            add_window(r.coord_x0, r.coord_y0, r.coord_x0, r.coord_y0);
            add_byte(DCS_MEM_WRITE, 1'b0);
            add_byte(r.pixel_color[15:8], 1'b1);
            add_byte(r.pixel_color[7:0], 1'b1);
          end
        end
        CMD_BEGIN_WRITE: add_byte(DCS_MEM_WRITE, 1'b0);
        default: begin
          add_byte(r.pixel_color[15:8], 1'b1);
          add_byte(r.pixel_color[7:0], 1'b1);
        end
      endcase
      if (expected_bytes.size() > start_count) begin
        tail = expected_bytes.pop_back();
        tail.last = 1'b1;
        expected_bytes.push_back(tail);
      end
    endfunction

    function void check_byte(result_t got);
      result_t want;
      if (expected_bytes.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected byte %h is_data %b last %b",
                   $realtime, got.out_byte, got.is_data, got.last);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
          got.last !== want.last) begin
        if (mismatches < 10)
          $display("%0t: expected byte %h is_data %b last %b, got %h %b %b",
                   $realtime, want.out_byte, want.is_data, want.last,
                   got.out_byte, got.is_data, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  request_t               request;
  logic                   push;
  logic                   full;
  result_t                result;
  logic                   empty;
  logic                   pop;

  dcs_stream_scoreboard sb;
  logic idle_on;
  int   quiet_cycles;
  int   pop_hold;

  lcd_window_command_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .push      (push),
    .full      (full),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb           = new();
    rst          = 1'b1;
    cfg_wen      = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    request      = '0;
    push         = 1'b0;
    pop          = 1'b0;
    idle_on      = 1'b1;
    quiet_cycles = 0;
    pop_hold     = 0;
  end

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      pop_hold <= $urandom_range(0, 8);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_request(request);
      if (pop && !empty) sb.check_byte(result);
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic request_t make_req(logic [1:0] cmd, logic [15:0] x0,
                                        logic [15:0] y0, logic [15:0] x1,
                                        logic [15:0] y1, logic [15:0] color);
    request_t r;
    r.command     = cmd;
    r.coord_x0    = x0;
    r.coord_y0    = y0;
    r.coord_x1    = x1;
    r.coord_y1    = y1;
    r.pixel_color = color;
    return r;
  endfunction

  function automatic logic [15:0] pick_coord(logic [SIZE_W-1:0] size);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {5'd0, size};
      3: return {5'd0, size} - 16'd1;
      4: return 16'($urandom);
      default: return (size == 0) ? 16'($urandom) : 16'($urandom_range(0, size - 1));
    endcase
  endfunction

  function automatic logic [15:0] point_coord(logic [SIZE_W-1:0] size);
    if (size == 0 || $urandom_range(0, 4) == 0) return pick_coord(size);
    return 16'($urandom_range(0, size - 1));
  endfunction

  task automatic send(input request_t r);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    request <= r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_panel(input logic [DIR_W-1:0] dir, input logic [SIZE_W-1:0] w,
                           input logic [SIZE_W-1:0] h);
    write_reg(REG_DIRECTION, CFG_DATA_W'(dir));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    @(negedge clk);
    cfg_wen      <= 1'b0;
    sb.direction = dir;
    sb.width     = w;
    sb.height    = h;
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(input int count);
    int          sent;
    int          kind;
    int          pixels;
    request_t    last_window;
    logic [15:0] px;
    logic [15:0] py;
    sent        = 0;
    last_window = make_req(CMD_SET_WINDOW, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        last_window = make_req(CMD_SET_WINDOW, point_coord(sb.width),
                               point_coord(sb.height), pick_coord(sb.width),
                               pick_coord(sb.height), 16'($urandom));
        send(last_window);
        send(make_req(CMD_BEGIN_WRITE, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom)));
        pixels = $urandom_range(1, 3);
        for (int i = 0; i < pixels; i++)
          send(make_req(CMD_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom)));
        sent += 2 + pixels;
      end else if (kind <= 6) begin
        px = point_coord(sb.width);
        py = point_coord(sb.height);
        send(make_req(CMD_DRAW_POINT, px, py, 16'($urandom), 16'($urandom),
                      16'($urandom)));
        if ($urandom_range(0, 2) == 0) begin
          send(make_req(CMD_DRAW_POINT, px, py, 16'($urandom), 16'($urandom),
                        16'($urandom)));
          sent++;
        end
        sent++;
      end else if (kind == 7) begin
        if ($urandom_range(0, 1) == 0)
          last_window = make_req(CMD_SET_WINDOW, 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom));
        send(last_window);
        sent++;
      end else begin
        send(make_req(kind == 8 ? CMD_BEGIN_WRITE : CMD_PIXEL, 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(make_req(CMD_SET_WINDOW, 16'd0, 16'd0, 16'd239, 16'd239, 16'h0000));
    send(make_req(CMD_SET_WINDOW, 16'd0, 16'd0, 16'd239, 16'd239, 16'hFFFF));
    send(make_req(CMD_SET_WINDOW, 16'd0, 16'd5, 16'd239, 16'd239, 16'h0000));
    send(make_req(CMD_SET_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(make_req(CMD_SET_WINDOW, 16'd1000, 16'd500, 16'd2000, 16'd100, 16'h0000));
    send(make_req(CMD_BEGIN_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(make_req(CMD_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    send(make_req(CMD_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send(make_req(CMD_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hA55A));
    send(make_req(CMD_DRAW_POINT, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(make_req(CMD_DRAW_POINT, 16'd0, 16'd0, 16'h0000, 16'h0000, 16'h1234));
    send(make_req(CMD_DRAW_POINT, 16'd240, 16'd0, 16'h0000, 16'h0000, 16'h5AA5));
    send(make_req(CMD_DRAW_POINT, 16'd0, 16'd240, 16'h0000, 16'h0000, 16'h5AA5));
    send(make_req(CMD_DRAW_POINT, 16'd239, 16'd239, 16'h0000, 16'h0000, 16'h0000));
    send(make_req(CMD_DRAW_POINT, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
    send(make_req(CMD_BEGIN_WRITE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send(make_req(CMD_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5AA5));
    random_traffic(RANDOM_PER_PHASE);
    drain();

    set_panel(DIR_X_FAR, 11'd1, 11'd1);
    send(make_req(CMD_DRAW_POINT, 16'd0, 16'd0, 16'd0, 16'd0, 16'hC3C3));
    send(make_req(CMD_DRAW_POINT, 16'd1, 16'd0, 16'd0, 16'd0, 16'hC3C3));
    random_traffic(RANDOM_PER_PHASE);
    drain();

    set_panel(DIR_Y_FAR, 11'd1024, 11'd1024);
    random_traffic(RANDOM_PER_PHASE);
    drain();

    set_panel(DIR_Y_NEAR, 11'd0, 11'd0);
    random_traffic(RANDOM_PER_PHASE);
    drain();

    set_panel(DIR_X_NEAR, 11'd2047, 11'd2047);
    random_traffic(RANDOM_PER_PHASE);
    drain();

    set_panel(DIR_X_FAR, 11'd240, 11'd320);
    random_traffic(RANDOM_PER_PHASE);
    drain();

    set_panel(DIR_Y_FAR, 11'($urandom_range(1, 200)), 11'($urandom_range(1, 200)));
    random_traffic(RANDOM_PER_PHASE);
    drain();

    set_panel(DIR_Y_NEAR, 11'd135, 11'd240);
    idle_on = 1'b0;
    random_traffic(RANDOM_PER_PHASE);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
